// ----- rtl/box_volume_strip_generator_assert.svh -----
// Assertion macros shared by the box strip checker.
`ifndef BOX_VOLUME_STRIP_GENERATOR_ASSERT_SVH
`define BOX_VOLUME_STRIP_GENERATOR_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define BVS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("box strip check failed");

// Check a consequent in the cycle after its antecedent.
`define BVS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("box strip check failed");

`endif

// ----- rtl/bvs_pkg.sv -----
// Shared widths, register codes and strip order table for the box strip generator.
`timescale 1ns / 1ps

package bvs_pkg;

   localparam int CENTER_W   = 32;
   localparam int AXIS_W     = 16;
   localparam int EXT_W      = 31;
   localparam int COLOR_W    = 32;
   localparam int POS_W      = 32;
   localparam int AXIS_FRAC  = 14;
   localparam int NUM_AXES   = 3;
   localparam int CORNER_W   = 3;
   localparam int FADE_W     = 2;
   localparam int IDX_W      = 6;
   localparam int STRIP_LEN  = 34;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Signed axis times zero-extended extent, then the sum of three such terms and the center.
   localparam int PROD_W = AXIS_W + EXT_W + 1;
   localparam int SUM_W  = PROD_W + 2;

   localparam logic [IDX_W-1:0]     LAST_INDEX  = IDX_W'(STRIP_LEN - 1);
   localparam logic [EXT_W-1:0]     EXT_RESET   = EXT_W'(65536);
   localparam logic [COLOR_W-1:0]   COLOR_RESET = '1;
   localparam logic [AXIS_FRAC-1:0] ROUND_LSBS  = AXIS_FRAC'(1 << (AXIS_FRAC - 1));

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE,
      CSR_HALF_X,
      CSR_HALF_Y,
      CSR_HALF_Z,
      CSR_COLOR
   } csr_index_type;

   // corner bit 0: +right, bit 1: +up, bit 2: +forward
   typedef struct packed {
      logic [CORNER_W-1:0] corner;
      logic                tex_v;
      logic                tex_u;
      logic [FADE_W-1:0]   fade;
   } strip_entry_type;

   // Strip order: front, back, left, right, bottom, top, with joints between faces.
   function automatic strip_entry_type strip_lookup(input logic [IDX_W-1:0] k);
      strip_entry_type e;
      case (k)
         6'd0:  e = {3'd4, 2'd0, 2'd2};
         6'd1:  e = {3'd5, 2'd1, 2'd2};
         6'd2:  e = {3'd6, 2'd2, 2'd2};
         6'd3:  e = {3'd7, 2'd3, 2'd2};
         6'd4:  e = {3'd7, 2'd3, 2'd2};
         6'd5:  e = {3'd1, 2'd0, 2'd2};
         6'd6:  e = {3'd1, 2'd0, 2'd2};
         6'd7:  e = {3'd0, 2'd1, 2'd2};
         6'd8:  e = {3'd3, 2'd2, 2'd2};
         6'd9:  e = {3'd2, 2'd3, 2'd2};
         6'd10: e = {3'd2, 2'd3, 2'd2};
         6'd11: e = {3'd0, 2'd0, 2'd1};
         6'd12: e = {3'd0, 2'd0, 2'd1};
         6'd13: e = {3'd4, 2'd1, 2'd1};
         6'd14: e = {3'd2, 2'd2, 2'd1};
         6'd15: e = {3'd6, 2'd3, 2'd1};
         6'd16: e = {3'd6, 2'd3, 2'd1};
         6'd17: e = {3'd5, 2'd0, 2'd1};
         6'd18: e = {3'd5, 2'd0, 2'd1};
         6'd19: e = {3'd1, 2'd1, 2'd1};
         6'd20: e = {3'd7, 2'd2, 2'd1};
         6'd21: e = {3'd3, 2'd3, 2'd1};
         6'd22: e = {3'd3, 2'd3, 2'd1};
         6'd23: e = {3'd0, 2'd0, 2'd1};
         6'd24: e = {3'd0, 2'd0, 2'd1};
         6'd25: e = {3'd1, 2'd1, 2'd1};
         6'd26: e = {3'd4, 2'd2, 2'd1};
         6'd27: e = {3'd5, 2'd3, 2'd1};
         6'd28: e = {3'd5, 2'd3, 2'd1};
         6'd29: e = {3'd2, 2'd0, 2'd1};
         6'd30: e = {3'd2, 2'd0, 2'd1};
         6'd31: e = {3'd6, 2'd1, 2'd1};
         6'd32: e = {3'd3, 2'd2, 2'd1};
         6'd33: e = {3'd7, 2'd3, 2'd1};
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

// ----- rtl/bvs_req_if.sv -----
// Pose item channel: valid, ready and the box center and axes.
`timescale 1ns / 1ps

interface bvs_req_if import bvs_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic signed [CENTER_W-1:0] center_x;
   logic signed [CENTER_W-1:0] center_y;
   logic signed [CENTER_W-1:0] center_z;
   logic signed [AXIS_W-1:0]   right_x;
   logic signed [AXIS_W-1:0]   right_y;
   logic signed [AXIS_W-1:0]   right_z;
   logic signed [AXIS_W-1:0]   up_x;
   logic signed [AXIS_W-1:0]   up_y;
   logic signed [AXIS_W-1:0]   up_z;
   logic signed [AXIS_W-1:0]   forward_x;
   logic signed [AXIS_W-1:0]   forward_y;
   logic signed [AXIS_W-1:0]   forward_z;

   modport source (
      output valid, center_x, center_y, center_z,
             right_x, right_y, right_z, up_x, up_y, up_z,
             forward_x, forward_y, forward_z,
      input  ready
   );

   modport sink (
      input  valid, center_x, center_y, center_z,
             right_x, right_y, right_z, up_x, up_y, up_z,
             forward_x, forward_y, forward_z,
      output ready
   );

endinterface

// ----- rtl/bvs_rsp_if.sv -----
// Vertex item channel: valid, ready and one strip vertex.
`timescale 1ns / 1ps

interface bvs_rsp_if import bvs_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;
   logic                    tex_u;
   logic                    tex_v;
   logic [FADE_W-1:0]       fade_age;
   logic [COLOR_W-1:0]      color_out;
   logic [IDX_W-1:0]        vertex_index;
   logic                    last;

   modport source (
      output valid, pos_x, pos_y, pos_z, tex_u, tex_v, fade_age,
             color_out, vertex_index, last,
      input  ready
   );

   modport sink (
      input  valid, pos_x, pos_y, pos_z, tex_u, tex_v, fade_age,
             color_out, vertex_index, last,
      output ready
   );

endinterface

// ----- rtl/box_volume_strip_generator.sv -----
// Top level of the oriented box triangle strip generator.
`timescale 1ns / 1ps

// Each pose item (center plus right, up and forward axes) becomes a 34-vertex
// triangle strip over the box faces front, back, left, right, bottom, top, with
// degenerate joint vertices between faces. The block emits one vertex per cycle
// while rsp_port.ready is high, so a pose holds the result channel for its 34
// vertices; that single vertex port sets the throughput. The design is four
// registers deep: a pose register, a product register (nine axis-by-extent
// multiplies), a corner sum register and the vertex output register. The next
// pose is taken into the pose register while the current strip is still going
// out and starts its strip right after the previous last vertex, without a gap.
// With enable cleared a pose is consumed and yields no vertices. Positions are
// rounded to nearest (ties upward) and saturated to the signed 32-bit range.
// Write the configuration registers only while no strip is in flight.
module box_volume_strip_generator import bvs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bvs_req_if.sink               req_port,
   bvs_rsp_if.source             rsp_port,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic               enable_ff;
   logic [EXT_W-1:0]   ext_ff [NUM_AXES];
   logic [COLOR_W-1:0] color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         ext_ff[0] <= EXT_RESET;
         ext_ff[1] <= EXT_RESET;
         ext_ff[2] <= EXT_RESET;
         color_ff  <= COLOR_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE: enable_ff <= csr_wdata[0];
            CSR_HALF_X: ext_ff[0] <= csr_wdata[EXT_W-1:0];
            CSR_HALF_Y: ext_ff[1] <= csr_wdata[EXT_W-1:0];
            CSR_HALF_Z: ext_ff[2] <= csr_wdata[EXT_W-1:0];
            CSR_COLOR:  color_ff  <= csr_wdata[COLOR_W-1:0];
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Handshake and stage advance
   // ------------------------------------------------------------------
   logic             pose_vld_ff, pose_vld_in;
   logic             gen_vld_ff, gen_vld_in;
   logic [IDX_W-1:0] gen_k_ff, gen_k_in;
   logic             sum_vld_ff, sum_vld_in;
   logic             rsp_vld_ff, rsp_vld_in;

   logic out_free, sum_free, gen_adv, gen_done, gen_free;
   logic pose_drop, gen_load, pose_take, req_ready, req_acc;

   always_comb begin
      out_free  = !rsp_vld_ff || rsp_port.ready;
      sum_free  = !sum_vld_ff || out_free;
      gen_adv   = gen_vld_ff && sum_free;
      gen_done  = gen_adv && (gen_k_ff == LAST_INDEX);
      gen_free  = !gen_vld_ff || gen_done;
      // A disabled pose leaves the pose register without reaching the generator.
      pose_drop = pose_vld_ff && !enable_ff;
      gen_load  = pose_vld_ff && enable_ff && gen_free;
      pose_take = pose_drop || gen_load;
      req_ready = !pose_vld_ff || pose_take;
      req_acc   = req_port.valid && req_ready;

      pose_vld_in = req_acc ? 1'b1 : (pose_take ? 1'b0 : pose_vld_ff);
      gen_vld_in  = gen_load ? 1'b1 : (gen_done ? 1'b0 : gen_vld_ff);
      gen_k_in    = gen_load ? '0 : (gen_adv ? IDX_W'(gen_k_ff + 1'b1) : gen_k_ff);
      sum_vld_in  = sum_free ? gen_vld_ff : sum_vld_ff;
      rsp_vld_in  = out_free ? sum_vld_ff : rsp_vld_ff;
   end

   assign req_port.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_vld_ff <= 1'b0;
         gen_vld_ff  <= 1'b0;
         gen_k_ff    <= '0;
         sum_vld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         pose_vld_ff <= pose_vld_in;
         gen_vld_ff  <= gen_vld_in;
         gen_k_ff    <= gen_k_in;
         sum_vld_ff  <= sum_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // ------------------------------------------------------------------
   // Pose register: hold the accepted item, axis index [axis][component]
   // ------------------------------------------------------------------
   logic signed [CENTER_W-1:0] center_ff [NUM_AXES];
   logic signed [AXIS_W-1:0]   axis_ff   [NUM_AXES][NUM_AXES];

   always_ff @(posedge clock) begin
      if (req_acc) begin
         center_ff[0]  <= req_port.center_x;
         center_ff[1]  <= req_port.center_y;
         center_ff[2]  <= req_port.center_z;
         axis_ff[0][0] <= req_port.right_x;
         axis_ff[0][1] <= req_port.right_y;
         axis_ff[0][2] <= req_port.right_z;
         axis_ff[1][0] <= req_port.up_x;
         axis_ff[1][1] <= req_port.up_y;
         axis_ff[1][2] <= req_port.up_z;
         axis_ff[2][0] <= req_port.forward_x;
         axis_ff[2][1] <= req_port.forward_y;
         axis_ff[2][2] <= req_port.forward_z;
      end
   end

   // ------------------------------------------------------------------
   // Product register: axis component times half extent, center in Q.30
   // ------------------------------------------------------------------
   logic signed [PROD_W-1:0] prod_in [NUM_AXES][NUM_AXES];
   logic signed [PROD_W-1:0] prod_ff [NUM_AXES][NUM_AXES];
   logic signed [SUM_W-1:0]  base_in [NUM_AXES];
   logic signed [SUM_W-1:0]  base_ff [NUM_AXES];
   logic signed [EXT_W:0]    ext_sgn [NUM_AXES];

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         ext_sgn[a] = {1'b0, ext_ff[a]};
         for (int c = 0; c < NUM_AXES; c++) begin
            prod_in[a][c] = PROD_W'(axis_ff[a][c]) * PROD_W'(ext_sgn[a]);
         end
      end
      // Center shifted into the product scale, with the rounding half folded in.
      for (int c = 0; c < NUM_AXES; c++) begin
         base_in[c] = {{(SUM_W - CENTER_W - AXIS_FRAC){center_ff[c][CENTER_W-1]}},
                       center_ff[c], ROUND_LSBS};
      end
   end

   always_ff @(posedge clock) begin
      if (gen_load) begin
         prod_ff <= prod_in;
         base_ff <= base_in;
      end
   end

   // ------------------------------------------------------------------
   // Corner sum register: pick the strip vertex, add signed terms
   // ------------------------------------------------------------------
   strip_entry_type         gen_entry;
   logic signed [SUM_W-1:0] sum_in [NUM_AXES];
   logic signed [SUM_W-1:0] sum_ff [NUM_AXES];
   strip_entry_type         sum_entry_ff;
   logic [IDX_W-1:0]        sum_idx_ff;

   always_comb begin
      gen_entry = strip_lookup(gen_k_ff);
      for (int c = 0; c < NUM_AXES; c++) begin
         sum_in[c] = base_ff[c];
         for (int a = 0; a < NUM_AXES; a++) begin
            if (gen_entry.corner[a]) begin
               sum_in[c] = sum_in[c] + SUM_W'(prod_ff[a][c]);
            end else begin
               sum_in[c] = sum_in[c] - SUM_W'(prod_ff[a][c]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (gen_adv) begin
         sum_ff       <= sum_in;
         sum_entry_ff <= gen_entry;
         sum_idx_ff   <= gen_k_ff;
      end
   end

   // ------------------------------------------------------------------
   // Vertex output register: drop fraction bits and saturate
   // ------------------------------------------------------------------
   localparam int Q_W = SUM_W - AXIS_FRAC;

   logic [Q_W-1:0]   quot [NUM_AXES];
   logic [POS_W-1:0] pos_in [NUM_AXES];
   logic [POS_W-1:0] pos_ff [NUM_AXES];
   logic             tex_u_ff, tex_v_ff;
   logic [FADE_W-1:0] fade_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             last_ff;

   always_comb begin
      for (int c = 0; c < NUM_AXES; c++) begin
         quot[c] = sum_ff[c][SUM_W-1:AXIS_FRAC];
         if ((&quot[c][Q_W-1:POS_W-1]) || !(|quot[c][Q_W-1:POS_W-1])) begin
            pos_in[c] = quot[c][POS_W-1:0];
         end else if (quot[c][Q_W-1]) begin
            pos_in[c] = {1'b1, {(POS_W-1){1'b0}}};
         end else begin
            pos_in[c] = {1'b0, {(POS_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && sum_vld_ff) begin
         pos_ff   <= pos_in;
         tex_u_ff <= sum_entry_ff.tex_u;
         tex_v_ff <= sum_entry_ff.tex_v;
         fade_ff  <= sum_entry_ff.fade;
         idx_ff   <= sum_idx_ff;
         last_ff  <= (sum_idx_ff == LAST_INDEX);
      end
   end

   assign rsp_port.valid        = rsp_vld_ff;
   assign rsp_port.pos_x        = pos_ff[0];
   assign rsp_port.pos_y        = pos_ff[1];
   assign rsp_port.pos_z        = pos_ff[2];
   assign rsp_port.tex_u        = tex_u_ff;
   assign rsp_port.tex_v        = tex_v_ff;
   assign rsp_port.fade_age     = fade_ff;
   // The user must keep color fixed while a strip is in flight; the block does not enforce it.
   assign rsp_port.color_out    = color_ff;
   assign rsp_port.vertex_index = idx_ff;
   assign rsp_port.last         = last_ff;

endmodule

// ----- rtl/bvs_checker.sv -----
// Port-level checker for the box strip generator and its bind.
`timescale 1ns / 1ps

`include "box_volume_strip_generator_assert.svh"

module bvs_checker import bvs_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [IDX_W-1:0]        rsp_vertex_index,
   input logic                    rsp_last,
   input logic signed [POS_W-1:0] rsp_pos_x
);

   // Hold a stalled vertex.
   `BVS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_vertex_index) && $stable(rsp_pos_x))

   // Flag the end of the strip exactly on its final vertex.
   `BVS_ASSERT_IMPL(a_last_at_end, clock, reset, rsp_valid, rsp_last == (rsp_vertex_index == LAST_INDEX))

   // Advance the index by one within a strip.
   `BVS_ASSERT_IMPL(a_index_step, clock, reset, rsp_valid && !$past(reset) && $past(rsp_valid && rsp_ready && !rsp_last), rsp_vertex_index == $past(rsp_vertex_index) + 1'b1)

   // Restart at vertex zero after a finished strip.
   `BVS_ASSERT_IMPL(a_strip_restart, clock, reset, rsp_valid && !$past(reset) && $past(rsp_valid && rsp_ready && rsp_last), rsp_vertex_index == '0)

endmodule

bind box_volume_strip_generator bvs_checker u_bvs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_vertex_index (rsp_port.vertex_index),
   .rsp_last         (rsp_port.last),
   .rsp_pos_x        (rsp_port.pos_x)
);
